### rtl/assert_macros.svh
// Assertion macros for the RTL of the cache set, used by lru_cache_set.
// Depends on nothing; the using module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cache set assertion failed");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("cache set forbidden condition seen");

`endif

### rtl/lcs_pkg.sv
// Types and constants of the LRU cache set.
// Used by lcs_cell, lcs_stats and lru_cache_set; depends on nothing.
package lcs_pkg;

    localparam int TAG_BITS = 20;
    localparam int CNT_BITS = 32;
    localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

    // Access kind codes.
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // One access item.
    typedef struct packed {
        logic                req_type;
        logic [TAG_BITS-1:0] tag;
    } req_t;

    // One result item.
    typedef struct packed {
        logic                hit;
        logic                dirty_evict;
        logic [CNT_BITS-1:0] hit_count;
        logic [CNT_BITS-1:0] miss_count;
        logic [CNT_BITS-1:0] read_miss_count;
        logic [CNT_BITS-1:0] write_miss_count;
        logic [CNT_BITS-1:0] dirty_evict_count;
    } res_t;

    // Contents of one recency position.
    typedef struct packed {
        logic                valid;
        logic                dirty;
        logic [TAG_BITS-1:0] tag;
    } entry_t;

    // Lookup status passed down the recency chain.
    typedef struct packed {
        logic found;   // a stop position was seen at or before this cell
        logic hit;     // that stop was a valid tag match
        logic dirty;   // dirty bit of the stop entry, or of this cell if none
    } link_t;

    // Events of one access for the statistics counters.
    typedef struct packed {
        logic hit;
        logic write;
        logic devict;
    } stat_evt_t;

endpackage

### rtl/lcs_cell.sv
// One recency position of the cache set: an entry, its tag compare and its shift.
// Depends on lcs_pkg.
module lcs_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic [lcs_pkg::TAG_BITS-1:0] look_tag,
    input  lcs_pkg::entry_t              left,
    input  lcs_pkg::link_t               link_in,
    output lcs_pkg::entry_t              entry,
    output lcs_pkg::link_t               link_out
);

    lcs_pkg::entry_t entry_reg;
    lcs_pkg::entry_t entry_next;
    logic            stop;

    // The lookup stops at the first invalid entry or the first valid match.
    assign stop = !entry_reg.valid || (entry_reg.tag == look_tag);

    always_comb
    begin
        link_out.found = link_in.found | stop;
        link_out.hit   = link_in.found ? link_in.hit   : (stop & entry_reg.valid);
        link_out.dirty = link_in.found ? link_in.dirty : entry_reg.dirty;
    end

    // Positions up to the stop shift one step toward the least-recent end.
    always_comb
    begin
        entry_next = entry_reg;
        if (en && !link_in.found)
        begin
            entry_next = left;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

### rtl/lcs_stats.sv
// Saturating access statistics of the cache set.
// Depends on lcs_pkg.
module lcs_stats (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  lcs_pkg::stat_evt_t           evt,
    output logic [lcs_pkg::CNT_BITS-1:0] hit_count,
    output logic [lcs_pkg::CNT_BITS-1:0] miss_count,
    output logic [lcs_pkg::CNT_BITS-1:0] read_miss_count,
    output logic [lcs_pkg::CNT_BITS-1:0] write_miss_count,
    output logic [lcs_pkg::CNT_BITS-1:0] dirty_evict_count
);

    logic [lcs_pkg::CNT_BITS-1:0] hit_reg,   hit_next;
    logic [lcs_pkg::CNT_BITS-1:0] miss_reg,  miss_next;
    logic [lcs_pkg::CNT_BITS-1:0] rmiss_reg, rmiss_next;
    logic [lcs_pkg::CNT_BITS-1:0] wmiss_reg, wmiss_next;
    logic [lcs_pkg::CNT_BITS-1:0] devct_reg, devct_next;

    function automatic logic [lcs_pkg::CNT_BITS-1:0] sat_inc(
        input logic [lcs_pkg::CNT_BITS-1:0] v
    );
        return (v == lcs_pkg::CNT_MAX) ? v : v + 1'b1;
    endfunction

    // Each counter steps once for its event and holds at its maximum.
    always_comb
    begin
        hit_next   = hit_reg;
        miss_next  = miss_reg;
        rmiss_next = rmiss_reg;
        wmiss_next = wmiss_reg;
        devct_next = devct_reg;
        if (en)
        begin
            if (evt.hit)
            begin
                hit_next = sat_inc(hit_reg);
            end
            else
            begin
                miss_next = sat_inc(miss_reg);
                if (evt.write == lcs_pkg::REQ_WRITE)
                begin
                    wmiss_next = sat_inc(wmiss_reg);
                end
                else
                begin
                    rmiss_next = sat_inc(rmiss_reg);
                end
            end
            if (evt.devict)
            begin
                devct_next = sat_inc(devct_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg   <= '0;
            miss_reg  <= '0;
            rmiss_reg <= '0;
            wmiss_reg <= '0;
            devct_reg <= '0;
        end
        else
        begin
            hit_reg   <= hit_next;
            miss_reg  <= miss_next;
            rmiss_reg <= rmiss_next;
            wmiss_reg <= wmiss_next;
            devct_reg <= devct_next;
        end
    end

    assign hit_count         = hit_reg;
    assign miss_count        = miss_reg;
    assign read_miss_count   = rmiss_reg;
    assign write_miss_count  = wmiss_reg;
    assign dirty_evict_count = devct_reg;

endmodule

### rtl/lru_cache_set.sv
// Top level of one set of a set-associative cache with true LRU replacement.
// Depends on lcs_pkg, lcs_cell, lcs_stats and assert_macros.svh.
//
// Usage:
//   An access item (req.req_type, req.tag) is accepted at a rising edge with
//   start high and busy low. busy is always low: one item may be accepted in
//   every cycle. Each accepted item gives one result item on res, marked by
//   done for exactly one cycle, in the cycle right after acceptance.
//   The set is a chain of NUM_WAYS cells kept in recency order, most recent
//   first. All cells compare the tag at once, and a ripple through the chain
//   picks the first invalid or matching position; that entry, or the new tag,
//   goes to the front while the cells before it shift one step back. The
//   ripple over NUM_WAYS cells sets the cycle time.
//   The receiver cannot hold results off; a result is shown for one cycle
//   only. Reset clears all valid and dirty bits and all counters; no
//   clearing pass is needed, so items are taken from the first cycle.
`include "assert_macros.svh"

module lru_cache_set #(
    parameter int NUM_WAYS = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  lcs_pkg::req_t req,
    output logic          done,
    output lcs_pkg::res_t res
);

    lcs_pkg::entry_t          entries [NUM_WAYS];
    lcs_pkg::link_t           links   [NUM_WAYS+1];
    lcs_pkg::entry_t          front;
    lcs_pkg::stat_evt_t       evt;
    logic                     accept;
    logic                     done_reg;
    logic                     hit_reg;
    logic                     devict_reg;
    logic [NUM_WAYS-1:0]      valid_vec;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // The chain starts with nothing found yet.
    assign links[0] = '0;

    // Entry written to the most-recent position.
    always_comb
    begin
        front.valid = 1'b1;
        front.tag   = req.tag;
        front.dirty = links[NUM_WAYS].hit &
                      (links[NUM_WAYS].dirty | (req.req_type == lcs_pkg::REQ_WRITE));
    end

    // Row of recency cells, each fed by its more-recent neighbor, the first by the front entry.
    for (genvar i = 0; i < NUM_WAYS; i++)
    begin : g_cell
        lcs_pkg::entry_t left_entry;
        if (i == 0)
        begin : g_head
            assign left_entry = front;
        end
        else
        begin : g_body
            assign left_entry = entries[i-1];
        end

        lcs_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (accept),
            .look_tag (req.tag),
            .left     (left_entry),
            .link_in  (links[i]),
            .entry    (entries[i]),
            .link_out (links[i+1])
        );

        assign valid_vec[i] = entries[i].valid;
    end

    // A miss with no invalid way evicts the least-recent entry.
    always_comb
    begin
        evt.hit    = links[NUM_WAYS].hit;
        evt.write  = req.req_type;
        evt.devict = !links[NUM_WAYS].found & links[NUM_WAYS].dirty;
    end

    lcs_stats u_stats (
        .clk               (clk),
        .rst_n             (rst_n),
        .en                (accept),
        .evt               (evt),
        .hit_count         (res.hit_count),
        .miss_count        (res.miss_count),
        .read_miss_count   (res.read_miss_count),
        .write_miss_count  (res.write_miss_count),
        .dirty_evict_count (res.dirty_evict_count)
    );

    // Result flags and strobe, registered in the cycle after acceptance.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            hit_reg    <= 1'b0;
            devict_reg <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                hit_reg    <= evt.hit;
                devict_reg <= evt.devict;
            end
        end
    end

    assign done            = done_reg;
    assign res.hit         = hit_reg;
    assign res.dirty_evict = devict_reg;

    // Every accepted item gives exactly one result in the next cycle.
    `ASSERT_CLK(a_result_follows, accept |=> done)
    `ASSERT_CLK(a_result_has_item, done |-> $past(accept))
    // A hit never evicts.
    `ASSERT_NEVER(a_hit_no_evict, done && res.hit && res.dirty_evict)
    // Valid entries always fill the most-recent positions first.
    `ASSERT_NEVER(a_valid_prefix, (NUM_WAYS'(valid_vec + 1'b1) & valid_vec) != '0)
    // An eviction happens only in a full set.
    `ASSERT_CLK(a_evict_full, (done && res.dirty_evict) |-> (&valid_vec))

endmodule

### sim/lru_cache_set_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for lru_cache_set, one LRU-managed cache set.
// Depends on lcs_pkg and the lru_cache_set RTL; holds its own model of the set.
module lru_cache_set_test;

    localparam int WAYS       = 4;
    localparam int CYCLE_CAP  = 200000;
    localparam int TAIL_WAIT  = 8;
    localparam int RAND_ITEMS = 1700;

    typedef logic [lcs_pkg::TAG_BITS-1:0] tag_t;
    typedef logic [lcs_pkg::CNT_BITS-1:0] cnt_t;

    logic          clk   = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    lcs_pkg::req_t req   = '0;
    logic          busy;
    logic          done;
    lcs_pkg::res_t res;

    // Shadow state of the set, updated once per accepted item.
    tag_t shadow_tag [WAYS];
    logic shadow_valid [WAYS];
    logic shadow_dirty [WAYS];
    int   recency [WAYS];
    cnt_t hits_seen;
    cnt_t misses_seen;
    cnt_t read_misses_seen;
    cnt_t write_misses_seen;
    cnt_t dirty_evicts_seen;

    lcs_pkg::res_t awaited_results [$];
    int            mismatch_count = 0;
    int            cycle_count    = 0;
    logic          burst_mode     = 1'b0;

    lru_cache_set #(
        .NUM_WAYS(WAYS)
    ) u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .req  (req),
        .done (done),
        .res  (res)
    );

    always #6 clk = ~clk;

    // Run guard: a hang or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic cnt_t sat_inc(input cnt_t v);
        return (v == lcs_pkg::CNT_MAX) ? v : v + 1'b1;
    endfunction

    // Move the way at list position pos to the most-recent end.
    function automatic void promote(input int pos);
        int w;
        w = recency[pos];
        for (int p = pos; p > 0; p--)
            recency[p] = recency[p - 1];
        recency[0] = w;
    endfunction

    // Apply one access to the shadow set and return the result it must give.
    function automatic lcs_pkg::res_t lru_access(input lcs_pkg::req_t item);
        lcs_pkg::res_t o;
        int   w;
        logic settled;
        logic is_hit;
        logic devict;
        settled = 1'b0;
        is_hit  = 1'b0;
        devict  = 1'b0;
        for (int pos = 0; pos < WAYS; pos++)
        begin
            w = recency[pos];
            if (!settled && !shadow_valid[w])
            begin
                shadow_valid[w] = 1'b1;
                shadow_tag[w]   = item.tag;
                shadow_dirty[w] = 1'b0;
                promote(pos);
                settled = 1'b1;
            end
            else if (!settled && shadow_tag[w] == item.tag)
            begin
                is_hit = 1'b1;
                if (item.req_type == lcs_pkg::REQ_WRITE)
                    shadow_dirty[w] = 1'b1;
                promote(pos);
                settled = 1'b1;
            end
        end
        // Full set with no match: replace the least-recent way, filled clean.
        if (!settled)
        begin
            w = recency[WAYS - 1];
            if (shadow_dirty[w])
            begin
                devict = 1'b1;
                dirty_evicts_seen = sat_inc(dirty_evicts_seen);
            end
            shadow_tag[w]   = item.tag;
            shadow_dirty[w] = 1'b0;
            promote(WAYS - 1);
        end
        if (is_hit)
            hits_seen = sat_inc(hits_seen);
        else
        begin
            misses_seen = sat_inc(misses_seen);
            if (item.req_type == lcs_pkg::REQ_WRITE)
                write_misses_seen = sat_inc(write_misses_seen);
            else
                read_misses_seen = sat_inc(read_misses_seen);
        end
        o.hit               = is_hit;
        o.dirty_evict       = devict;
        o.hit_count         = hits_seen;
        o.miss_count        = misses_seen;
        o.read_miss_count   = read_misses_seen;
        o.write_miss_count  = write_misses_seen;
        o.dirty_evict_count = dirty_evicts_seen;
        return o;
    endfunction

    task automatic compare_field(input string name, input cnt_t exp_v, input cnt_t act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // Predict at each accepted item, then check each result against the oldest one.
    always @(posedge clk)
    begin
        lcs_pkg::res_t exp_r;
        if (rst_n)
        begin
            if (start && !busy)
                awaited_results.push_back(lru_access(req));
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result with none awaited, expected nothing, actual %h",
                             $time, res);
                    mismatch_count++;
                end
                else
                begin
                    exp_r = awaited_results.pop_front();
                    compare_field("hit", cnt_t'(exp_r.hit), cnt_t'(res.hit));
                    compare_field("dirty_evict", cnt_t'(exp_r.dirty_evict),
                                  cnt_t'(res.dirty_evict));
                    compare_field("hit_count", exp_r.hit_count, res.hit_count);
                    compare_field("miss_count", exp_r.miss_count, res.miss_count);
                    compare_field("read_miss_count", exp_r.read_miss_count,
                                  res.read_miss_count);
                    compare_field("write_miss_count", exp_r.write_miss_count,
                                  res.write_miss_count);
                    compare_field("dirty_evict_count", exp_r.dirty_evict_count,
                                  res.dirty_evict_count);
                end
            end
        end
    end

    // Offer one item after a random gap, or none in burst mode, and return at the edge that takes it.
    task automatic send_access(input logic kind, input tag_t t);
        lcs_pkg::req_t item;
        int            gap;
        item.req_type = kind;
        item.tag      = t;
        gap = burst_mode ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req   <= item;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Stop sending and wait until every awaited result has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // Corners: invalid ways holding tag zero, extreme tags, write hits,
    // clean fill on a write miss, and clean and dirty evictions.
    task automatic test_directed_corners();
        send_access(lcs_pkg::REQ_READ, 20'h00000);
        send_access(lcs_pkg::REQ_WRITE, 20'h00000);
        send_access(lcs_pkg::REQ_WRITE, 20'hFFFFF);
        send_access(lcs_pkg::REQ_READ, 20'hFFFFF);
        send_access(lcs_pkg::REQ_WRITE, 20'h55555);
        send_access(lcs_pkg::REQ_WRITE, 20'hAAAAA);
        send_access(lcs_pkg::REQ_READ, 20'h12345);
        send_access(lcs_pkg::REQ_WRITE, 20'h55555);
        send_access(lcs_pkg::REQ_READ, 20'h00001);
        send_access(lcs_pkg::REQ_READ, 20'h00002);
        send_access(lcs_pkg::REQ_READ, 20'h00003);
        send_access(lcs_pkg::REQ_WRITE, 20'h00001);
        send_access(lcs_pkg::REQ_READ, 20'h00001);
        send_access(lcs_pkg::REQ_WRITE, 20'h80000);
        send_access(lcs_pkg::REQ_READ, 20'h00002);
        send_access(lcs_pkg::REQ_READ, 20'h7FFFF);
        send_access(lcs_pkg::REQ_WRITE, 20'h00003);
        send_access(lcs_pkg::REQ_WRITE, 20'hFFFFF);
        send_access(lcs_pkg::REQ_READ, 20'h00000);
        send_access(lcs_pkg::REQ_READ, 20'h00001);
    endtask

    // Short bursts, alternately back-to-back and with random gaps, each followed by a full drain.
    task automatic test_drain_pauses();
        for (int b = 0; b < 4; b++)
        begin
            burst_mode = (b % 2 == 0);
            for (int i = 0; i < 10; i++)
                send_access($urandom_range(0, 1) ? lcs_pkg::REQ_WRITE : lcs_pkg::REQ_READ,
                            20'h00010 + 20'($urandom_range(0, 5)));
            drain_results();
        end
        burst_mode = 1'b0;
    endtask

    // Segments over a small random tag pool, so hits, fills and evictions
    // all occur, with some fully random tags mixed in.
    task automatic test_random_traffic();
        tag_t pool [8];
        int   pool_size;
        int   sent;
        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            pool_size  = $urandom_range(2, 8);
            burst_mode = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 8; k++)
                pool[k] = tag_t'($urandom);
            for (int i = 0; i < 50; i++)
            begin
                if ($urandom_range(0, 99) < 85)
                    send_access($urandom_range(0, 1) ? lcs_pkg::REQ_WRITE : lcs_pkg::REQ_READ,
                                pool[$urandom_range(0, pool_size - 1)]);
                else
                    send_access($urandom_range(0, 1) ? lcs_pkg::REQ_WRITE : lcs_pkg::REQ_READ,
                                tag_t'($urandom));
                sent++;
            end
        end
        burst_mode = 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            shadow_tag[i]   = '0;
            shadow_valid[i] = 1'b0;
            shadow_dirty[i] = 1'b0;
            recency[i]      = i;
        end
        hits_seen         = '0;
        misses_seen       = '0;
        read_misses_seen  = '0;
        write_misses_seen = '0;
        dirty_evicts_seen = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_drain_pauses();
        test_random_traffic();

        drain_results();
        repeat (TAIL_WAIT) @(posedge clk);

        if (awaited_results.size() != 0)
        begin
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, awaited_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/lcs_pkg.sv
rtl/lcs_cell.sv
rtl/lcs_stats.sv
rtl/lru_cache_set.sv
sim/lru_cache_set_test.sv
